// ===== rtl/intensity_order_region_labeler_macros.svh =====
// Assertion macros for the intensity order region labeler.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef INTENSITY_ORDER_REGION_LABELER_MACROS_SVH
`define INTENSITY_ORDER_REGION_LABELER_MACROS_SVH

// same-cycle implication
`define IOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IOL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iol_pkg.sv =====
// Shared types and codes for the intensity order region labeler.
// No dependencies.
`timescale 1ns / 1ps
package iol_pkg;

    localparam int LBL_W = 15;
    localparam logic [LBL_W-1:0] LBL_LIMIT = 15'h7FFF;

    localparam logic [1:0] OUT_NEW     = 2'd0;
    localparam logic [1:0] OUT_JOIN    = 2'd1;
    localparam logic [1:0] OUT_CONTEST = 2'd2;
    localparam logic [1:0] OUT_NONE    = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic             vld;
        logic [LBL_W-1:0] lbl;
    } t_lane;

    typedef struct packed {
        logic [LBL_W-1:0] first;
        logic             several;
    } t_mrg;

endpackage

// ===== rtl/iol_label_mem.sv =====
// Label store: one write port, two registered read ports.
// Depends on iol_pkg for the label width.
`timescale 1ns / 1ps
module iol_label_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [iol_pkg::LBL_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr_a,
    input  logic [AW-1:0]             i_raddr_b,
    output logic [iol_pkg::LBL_W-1:0] o_rdata_a,
    output logic [iol_pkg::LBL_W-1:0] o_rdata_b
);
    import iol_pkg::*;

    logic [LBL_W-1:0] r_mem [DEPTH];
    logic [LBL_W-1:0] r_rdata_a;
    logic [LBL_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/iol_merge.sv =====
// Neighbor label gatherer: keeps the first nonzero label and a flag for a second distinct one.
// Depends on iol_pkg for lane and result types.
`timescale 1ns / 1ps
module iol_merge (
    input  logic           i_clk,
    input  logic           i_init,
    input  iol_pkg::t_lane i_lane_a,
    input  iol_pkg::t_lane i_lane_b,
    output iol_pkg::t_mrg  o_acc
);
    import iol_pkg::*;

    t_mrg r_acc;
    t_mrg n_acc;
    t_mrg mid;

    always_comb begin
        mid = r_acc;
        if (i_lane_a.vld && (i_lane_a.lbl != '0)) begin
            if (mid.first == '0) begin
                mid.first = i_lane_a.lbl;
            end else if (i_lane_a.lbl != mid.first) begin
                mid.several = 1'b1;
            end
        end
        n_acc = mid;
        if (i_lane_b.vld && (i_lane_b.lbl != '0)) begin
            if (n_acc.first == '0) begin
                n_acc.first = i_lane_b.lbl;
            end else if (i_lane_b.lbl != n_acc.first) begin
                n_acc.several = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/intensity_order_region_labeler.sv =====
// Top level of the intensity order region labeler: sequencer, config and result registers.
// Depends on iol_pkg, iol_label_mem, iol_merge and the macros header.
//
//  channel   signals                                    handshake
//  --------  -----------------------------------------  ------------------------
//  request   i_action i_pixel_x i_pixel_y               start && !busy
//  result    o_assigned_label o_outcome o_source_count  o_valid, one cycle
//  config    i_cfg_idx i_cfg_data                       i_cfg_we
//
// For an in-frame pixel the eight neighbor labels are read two per cycle over
// the two store read ports in S_RD, then S_FIN gathers the last pair and S_DEC
// decides and writes back.
// Out-of-frame requests answer next cycle and leave busy low.
// Reset and every clear sweep the store one entry a cycle over all
// MAX_WIDTH*MAX_HEIGHT entries with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module intensity_order_region_labeler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [7:0]                i_pixel_x,
    input  logic [7:0]                i_pixel_y,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [8:0]                i_cfg_data,
    output logic                      o_valid,
    output logic [iol_pkg::LBL_W-1:0] o_assigned_label,
    output logic [1:0]                o_outcome,
    output logic [iol_pkg::LBL_W-1:0] o_source_count
);
    import iol_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DEC  = 3'd4;

    localparam logic signed [1:0] NBR_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                                 2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] NBR_DY [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                 2'sd0, 2'sd1, 2'sd1, 2'sd1};

    logic [2:0]       r_state;
    logic [1:0]       r_step;
    logic [AW-1:0]    r_clr_addr;
    logic [8:0]       r_cfg_w;
    logic [8:0]       r_cfg_h;
    logic [LBL_W-1:0] r_next;
    logic [7:0]       r_x;
    logic [7:0]       r_y;
    logic [AW-1:0]    r_base;
    logic [1:0]       r_rv;
    logic             r_valid;
    logic [LBL_W-1:0] r_label;
    logic [1:0]       r_outcome;
    logic [LBL_W-1:0] r_count;

    logic [8:0]       w_use;
    logic [8:0]       h_use;
    logic             accept;
    logic             in_frame;
    logic [9:0]       nx [2];
    logic [9:0]       ny [2];
    logic [1:0]       lv;
    logic [AW-1:0]    raddr [2];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [LBL_W-1:0] mem_wdata;
    logic [LBL_W-1:0] rdata_a;
    logic [LBL_W-1:0] rdata_b;
    t_lane            lane_a;
    t_lane            lane_b;
    t_mrg             acc;
    logic             dec_write;
    logic [LBL_W-1:0] dec_label;
    logic [1:0]       dec_outcome;
    logic [LBL_W-1:0] dec_next;

    assign w_use = (r_cfg_w == 9'd0) ? 9'd1 :
                   ((32'(r_cfg_w) > MAX_WIDTH) ? 9'(MAX_WIDTH) : r_cfg_w);
    assign h_use = (r_cfg_h == 9'd0) ? 9'd1 :
                   ((32'(r_cfg_h) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_cfg_h);

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_frame = ({1'b0, i_pixel_x} < w_use) && ({1'b0, i_pixel_y} < h_use);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            nx[l] = {2'b00, r_x} + {{8{NBR_DX[2 * int'(r_step) + l][1]}},
                                    NBR_DX[2 * int'(r_step) + l]};
            ny[l] = {2'b00, r_y} + {{8{NBR_DY[2 * int'(r_step) + l][1]}},
                                    NBR_DY[2 * int'(r_step) + l]};
            lv[l] = (r_state == S_RD) && !nx[l][9] && (nx[l][8:0] < w_use)
                    && !ny[l][9] && (ny[l][8:0] < h_use);
            raddr[l] = AW'(32'(ny[l][8:0]) * MAX_WIDTH + 32'(nx[l][8:0]));
        end
    end

    assign lane_a = '{vld: r_rv[0], lbl: rdata_a};
    assign lane_b = '{vld: r_rv[1], lbl: rdata_b};

    iol_merge u_merge (
        .i_clk    (i_clk),
        .i_init   (accept),
        .i_lane_a (lane_a),
        .i_lane_b (lane_b),
        .o_acc    (acc)
    );

    always_comb begin
        dec_write   = 1'b0;
        dec_label   = '0;
        dec_outcome = OUT_CONTEST;
        dec_next    = r_next;
        if (acc.first == '0) begin
            if (r_next < LBL_LIMIT) begin
                dec_write   = 1'b1;
                dec_label   = r_next;
                dec_outcome = OUT_NEW;
                dec_next    = r_next + 1'b1;
            end
        end else if (!acc.several) begin
            dec_write   = 1'b1;
            dec_label   = acc.first;
            dec_outcome = OUT_JOIN;
        end
    end

    assign mem_we    = (r_state == S_CLR) || ((r_state == S_DEC) && dec_write);
    assign mem_waddr = (r_state == S_CLR) ? r_clr_addr : r_base;
    assign mem_wdata = (r_state == S_CLR) ? '0 : dec_label;

    iol_label_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr[0]),
        .i_raddr_b (raddr[1]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_step     <= '0;
            r_clr_addr <= '0;
            r_cfg_w    <= 9'd256;
            r_cfg_h    <= 9'd256;
            r_next     <= 15'd1;
            r_rv       <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_rv    <= lv;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_valid <= 1'b1;
                        if (!i_action) begin
                            r_next     <= 15'd1;
                            r_clr_addr <= '0;
                            r_state    <= S_CLR;
                        end else if (in_frame) begin
                            r_valid <= 1'b0;
                            r_step  <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd3) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_valid <= 1'b1;
                    r_next  <= dec_next;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x       <= i_pixel_x;
            r_y       <= i_pixel_y;
            r_base    <= AW'(32'(i_pixel_y) * MAX_WIDTH + 32'(i_pixel_x));
            r_label   <= '0;
            r_outcome <= OUT_NONE;
            r_count   <= i_action ? (r_next - 1'b1) : '0;
        end else if (r_state == S_DEC) begin
            r_label   <= dec_label;
            r_outcome <= dec_outcome;
            r_count   <= dec_next - 1'b1;
        end
    end

    assign o_valid          = r_valid;
    assign o_assigned_label = r_label;
    assign o_outcome        = r_outcome;
    assign o_source_count   = r_count;

`include "intensity_order_region_labeler_macros.svh"

    `IOL_ASSERT_IMP(a_new_is_count, o_valid && (o_outcome == OUT_NEW),
                    o_assigned_label == o_source_count, "new label differs from count")
    `IOL_ASSERT_IMP(a_unlab_zero,
                    o_valid && ((o_outcome == OUT_CONTEST) || (o_outcome == OUT_NONE)),
                    o_assigned_label == '0, "unlabelled result carries a label")
    `IOL_ASSERT_NXT(a_req_answered, start && !busy, o_valid || busy,
                    "request neither answered nor in progress")
    `IOL_ASSERT_IMP(a_write_when, mem_we, (r_state == S_CLR) || (r_state == S_DEC),
                    "store written outside sweep or decide")

endmodule

// ===== dv/intensity_order_region_labeler_tb.sv =====
// Self-checking testbench for the intensity order region labeler.
// Depends on iol_pkg and the intensity_order_region_labeler top level.
// Predicts every result from its own label map and compares each one field by field.
`timescale 1ns / 1ps
module intensity_order_region_labeler_tb;
    import iol_pkg::*;

    localparam int MAP_W = 256;
    localparam int MAP_H = 256;
    localparam int STALL_LIMIT = 300000;

    typedef struct {
        logic [LBL_W-1:0] label;
        logic [1:0]       outcome;
        logic [LBL_W-1:0] count;
    } t_label_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             i_action = 1'b1;
    logic [7:0]       i_pixel_x = '0;
    logic [7:0]       i_pixel_y = '0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = REG_WIDTH;
    logic [8:0]       i_cfg_data = '0;
    logic             o_valid;
    logic [LBL_W-1:0] o_assigned_label;
    logic [1:0]       o_outcome;
    logic [LBL_W-1:0] o_source_count;

    logic [LBL_W-1:0] label_map [0:MAP_W*MAP_H-1];
    logic [LBL_W-1:0] label_next;
    logic [8:0]       frame_w_reg;
    logic [8:0]       frame_h_reg;

    t_label_result pending_labels [$];
    int            error_count = 0;
    int            idle_pct = 0;
    int            segment_count = 0;
    int            stall_cycles = 0;

    intensity_order_region_labeler #(
        .MAX_WIDTH (MAP_W),
        .MAX_HEIGHT(MAP_H)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_assigned_label(o_assigned_label),
        .o_outcome       (o_outcome),
        .o_source_count  (o_source_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_label_map();
        for (int i = 0; i < MAP_W*MAP_H; i++) label_map[i] = '0;
        label_next = 1;
    endfunction

    function automatic int frame_dim(input logic [8:0] v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_label_result predict_label(input logic act, input logic [7:0] px,
                                                    input logic [7:0] py);
        t_label_result    r;
        int               w;
        int               h;
        int               nx;
        int               ny;
        logic [LBL_W-1:0] first;
        logic [LBL_W-1:0] v;
        logic             several;
        w = frame_dim(frame_w_reg, MAP_W);
        h = frame_dim(frame_h_reg, MAP_H);
        first = '0;
        several = 1'b0;
        r.label = '0;
        if (!act) begin
            clear_label_map();
            r.outcome = OUT_NONE;
            r.count = '0;
            return r;
        end
        if (px >= w || py >= h) begin
            r.outcome = OUT_NONE;
            r.count = label_next - 1'b1;
            return r;
        end
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                nx = int'(px) + dx;
                ny = int'(py) + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                    v = label_map[ny*MAP_W + nx];
                    if (v != 0) begin
                        if (first == 0) first = v;
                        else if (v != first) several = 1'b1;
                    end
                end
            end
        end
        if (first == 0) begin
            if (label_next < LBL_LIMIT) begin
                r.label = label_next;
                label_next = label_next + 1'b1;
                label_map[int'(py)*MAP_W + int'(px)] = r.label;
                r.outcome = OUT_NEW;
            end else begin
                r.outcome = OUT_CONTEST;
            end
        end else if (!several) begin
            r.label = first;
            label_map[int'(py)*MAP_W + int'(px)] = first;
            r.outcome = OUT_JOIN;
        end else begin
            r.outcome = OUT_CONTEST;
        end
        r.count = label_next - 1'b1;
        return r;
    endfunction

    task automatic send_request(input logic act, input logic [7:0] px, input logic [7:0] py);
        t_label_result exp_r;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_action  <= act;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        exp_r = predict_label(act, px, py);
        pending_labels = {pending_labels, exp_r};
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_labels.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WIDTH) frame_w_reg = data;
        else frame_h_reg = data;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [8:0] w, input logic [8:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    task automatic test_labeling();
        send_request(1'b1, 8'd0, 8'd0);
        send_request(1'b1, 8'd1, 8'd1);
        send_request(1'b1, 8'd0, 8'd0);
        send_request(1'b1, 8'd255, 8'd255);
        send_request(1'b1, 8'd255, 8'd0);
        send_request(1'b1, 8'd0, 8'd255);
        send_request(1'b1, 8'd40, 8'd40);
        send_request(1'b1, 8'd42, 8'd40);
        send_request(1'b1, 8'd41, 8'd40);
        send_request(1'b1, 8'd41, 8'd41);
        send_request(1'b1, 8'd60, 8'd60);
        send_request(1'b1, 8'd60, 8'd60);
        send_request(1'b1, 8'd61, 8'd60);
    endtask

    task automatic test_frame_limits();
        set_frame(9'd10, 9'd5);
        send_request(1'b1, 8'd10, 8'd0);
        send_request(1'b1, 8'd0, 8'd5);
        send_request(1'b1, 8'd9, 8'd4);
        send_request(1'b1, 8'd255, 8'd255);
        set_frame(9'd0, 9'd0);
        send_request(1'b1, 8'd0, 8'd0);
        send_request(1'b1, 8'd1, 8'd0);
        set_frame(9'd511, 9'd300);
        send_request(1'b1, 8'd255, 8'd255);
        // right neighbor falls outside the narrowed frame
        set_frame(9'd42, 9'd256);
        send_request(1'b1, 8'd41, 8'd40);
        set_frame(9'd256, 9'd256);
    endtask

    task automatic test_clear();
        send_request(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_request(1'b1, 8'd0, 8'd0);
        send_request(1'b1, 8'd2, 8'd2);
    endtask

    task automatic test_random_phase(input int n_items, input int pct);
        int         mode;
        int         ox;
        int         oy;
        int         span;
        logic [8:0] w;
        logic [8:0] h;
        idle_pct = pct;
        for (int done = 0; done < n_items; done += 100) begin
            segment_count++;
            mode = $urandom_range(0, 9);
            ox = 0;
            oy = 0;
            if (mode <= 5) begin
                w = (mode == 5) ? 9'($urandom_range(256, 511)) : 9'd256;
                h = (mode == 4) ? 9'($urandom_range(256, 511)) : 9'd256;
                ox = $urandom_range(0, 255);
                oy = $urandom_range(0, 255);
                span = $urandom_range(2, 10);
            end else if (mode <= 8) begin
                w = 9'($urandom_range(1, 24));
                h = 9'($urandom_range(1, 24));
                span = ((w > h) ? w : h) + 2;
            end else begin
                w = 9'($urandom_range(0, 1));
                h = 9'($urandom_range(0, 511));
                span = 4;
            end
            set_frame(w, h);
            if (segment_count % 6 == 5) begin
                send_request(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            repeat (100) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_request(1'b1, 8'(ox + $urandom_range(0, span)),
                                 8'(oy + $urandom_range(0, span)));
                end else begin
                    send_request(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_label_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_labels.size() == 0) begin
                $error("result with no request pending: label %0d outcome %0d count %0d",
                       o_assigned_label, o_outcome, o_source_count);
                error_count++;
            end else begin
                exp_r = pending_labels.pop_front();
                if (o_assigned_label !== exp_r.label) begin
                    $error("assigned_label: expected %0d, got %0d", exp_r.label,
                           o_assigned_label);
                    error_count++;
                end
                if (o_outcome !== exp_r.outcome) begin
                    $error("outcome: expected %0d, got %0d", exp_r.outcome, o_outcome);
                    error_count++;
                end
                if (o_source_count !== exp_r.count) begin
                    $error("source_count: expected %0d, got %0d", exp_r.count,
                           o_source_count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("intensity_order_region_labeler: mismatch");
                $finish;
            end
        end
    end

    initial begin
        clear_label_map();
        frame_w_reg = 9'd256;
        frame_h_reg = 9'd256;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 8;
        test_labeling();
        test_frame_limits();
        test_clear();
        test_random_phase(600, 8);
        test_random_phase(600, 63);
        test_random_phase(500, 0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_labels.size() == 0) begin
            $display("intensity_order_region_labeler: match");
        end else begin
            $display("intensity_order_region_labeler: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iol_pkg.sv
rtl/iol_label_mem.sv
rtl/iol_merge.sv
rtl/intensity_order_region_labeler.sv
dv/intensity_order_region_labeler_tb.sv
